>>> rtl/isuq_pkg.sv
// Package for the interval set union/query block.
// Holds sizes, operation, status and row command codes shared by the RTL files.
package isuq_pkg;
  localparam int unsigned FIELD_W   = 20;
  localparam int unsigned INDEX_W   = 5;
  localparam int unsigned COUNT_W   = 6;
  localparam int unsigned CAPACITY  = 32;
  localparam int unsigned KEY_WIDTH = 20;
  localparam int unsigned PTR_W     = $clog2(CAPACITY);

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_QUERY  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_REVERSED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CMD_HOLD  = 2'd0,
    CMD_RIGHT = 2'd1,
    CMD_LEFT  = 2'd2
  } cmd_t;
endpackage

>>> rtl/isuq_cell.sv
// One storage cell of the interval row: holds the two ends of one interval.
// Depends on isuq_pkg. Loads from the write port or from either neighbor.
module isuq_cell (
  input  logic                           clk,
  input  logic                           load,       // take the write port
  input  logic                           take_left,  // take the left neighbor
  input  logic                           take_right, // take the right neighbor
  input  logic [isuq_pkg::KEY_WIDTH-1:0] wr_low,
  input  logic [isuq_pkg::KEY_WIDTH-1:0] wr_high,
  input  logic [isuq_pkg::KEY_WIDTH-1:0] left_low,
  input  logic [isuq_pkg::KEY_WIDTH-1:0] left_high,
  input  logic [isuq_pkg::KEY_WIDTH-1:0] right_low,
  input  logic [isuq_pkg::KEY_WIDTH-1:0] right_high,
  output logic [isuq_pkg::KEY_WIDTH-1:0] low,
  output logic [isuq_pkg::KEY_WIDTH-1:0] high
);
  import isuq_pkg::*;

  logic [KEY_WIDTH-1:0] low_r, low_nxt, high_r, high_nxt;

  assign low  = low_r;
  assign high = high_r;

  always_comb begin
    priority if (load) begin
      low_nxt  = wr_low;
      high_nxt = wr_high;
    end else if (take_left) begin
      low_nxt  = left_low;
      high_nxt = left_high;
    end else if (take_right) begin
      low_nxt  = right_low;
      high_nxt = right_high;
    end else begin
      low_nxt  = low_r;
      high_nxt = high_r;
    end
  end

  always_ff @(posedge clk) begin
    low_r  <= low_nxt;
    high_r <= high_nxt;
  end
endmodule

>>> rtl/isuq_row.sv
// Row of interval cells with a shift path used to insert and compact.
// Depends on isuq_pkg and isuq_cell. The top level sequences shift and probe steps.
module isuq_row (
  input  logic                           clk,
  input  isuq_pkg::cmd_t                 cmd,
  input  logic [isuq_pkg::PTR_W-1:0]     pos,
  input  logic                           wr,
  input  logic [isuq_pkg::KEY_WIDTH-1:0] wr_low,
  input  logic [isuq_pkg::KEY_WIDTH-1:0] wr_high,
  input  logic [isuq_pkg::PTR_W-1:0]     rd_pos,
  output logic [isuq_pkg::KEY_WIDTH-1:0] rd_low,
  output logic [isuq_pkg::KEY_WIDTH-1:0] rd_high
);
  import isuq_pkg::*;

  logic [KEY_WIDTH-1:0] cell_low [CAPACITY];
  logic [KEY_WIDTH-1:0] cell_high [CAPACITY];

  // each cell takes from a neighbor or the write port; chain moves one slot a cycle
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam int unsigned NB_L = (g > 0) ? g - 1 : 0;
    localparam int unsigned NB_R = (g < CAPACITY - 1) ? g + 1 : g;
    logic load, take_left, take_right;

    assign load       = wr && (pos == PTR_W'(g));
    assign take_left  = (g > 0) && (cmd == CMD_RIGHT) && (PTR_W'(g) > pos);
    assign take_right = (g < CAPACITY - 1) && (cmd == CMD_LEFT) && (PTR_W'(g) >= pos);

    isuq_cell u_cell (
      .clk,
      .load,
      .take_left,
      .take_right,
      .wr_low,
      .wr_high,
      .left_low   (cell_low[NB_L]),
      .left_high  (cell_high[NB_L]),
      .right_low  (cell_low[NB_R]),
      .right_high (cell_high[NB_R]),
      .low        (cell_low[g]),
      .high       (cell_high[g])
    );
  end

  assign rd_low  = cell_low[rd_pos];
  assign rd_high = cell_high[rd_pos];
endmodule

>>> rtl/interval_set_union_query_top.sv
// Interval set union/query block: top level with the operation sequencer.
// Depends on isuq_pkg and isuq_row.
//
// Usage: one operation per input beat (clear, insert, query, read entry);
// exactly one result beat per operation, in order.
// The set lives in a row of cells that shifts one slot per cycle toward
// either neighbor; a sequencer walks a position pointer over the row.
// Steps: clear and a reversed insert answer straight from idle; read passes
// through S_READ; query compares one cell per cycle; insert scans one cell
// per cycle (S_FIND, S_MERGE), then opens a slot with one right shift (S_OPEN)
// or closes the gap with one left shift per surplus slot (S_CLOSE).
// One item is worked at a time; the next is taken in the cycle the result
// beat leaves the output register, so a stalled receiver keeps the block
// idle with the result held in that register.
// Reset empties the set (count zero); stored ends are undefined until
// written but never read past the count.
module interval_set_union_query_top (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_operation,
  input  logic [19:0]             in_range_low,
  input  logic [19:0]             in_range_high,
  input  logic [19:0]             in_probe_key,
  input  logic [4:0]              in_entry_index,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_hit,
  output logic [19:0]             out_entry_low,
  output logic [19:0]             out_entry_high,
  output logic                    out_entry_valid,
  output logic [5:0]              out_interval_count,
  output logic [1:0]              out_status
);
  import isuq_pkg::*;

  localparam int unsigned KW = KEY_WIDTH;
  localparam int unsigned PW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_QUERY = 7'b0000010,
    S_READ  = 7'b0000100,
    S_FIND  = 7'b0001000,
    S_MERGE = 7'b0010000,
    S_CLOSE = 7'b0100000,
    S_OPEN  = 7'b1000000
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;     // scan position
  logic [CW-1:0] first_r, first_nxt; // merge slot
  logic [CW-1:0] run_r, run_nxt;     // left shifts still to do
  logic [KW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, key_r, key_nxt;
  logic [4:0]    idx_r, idx_nxt;

  logic          ov_r, ov_nxt;
  logic          o_hit_r, o_hit_nxt, o_ev_r, o_ev_nxt;
  logic [19:0]   o_lo_r, o_lo_nxt, o_hi_r, o_hi_nxt;
  logic [1:0]    o_st_r, o_st_nxt;

  cmd_t          cmd;
  logic [PW-1:0] pos, rd_pos;
  logic          wr;
  logic [KW-1:0] wr_low, wr_high, rd_low, rd_high;

  isuq_row u_row (
    .clk, .cmd, .pos, .wr, .wr_low, .wr_high,
    .rd_pos, .rd_low, .rd_high
  );

  logic in_acc;
  assign in_ready = (state_r == S_IDLE) && (!ov_r || out_ready);
  assign in_acc   = in_valid && in_ready;
  assign rd_pos   = ptr_r[PW-1:0];

  logic [KW:0] rl1, rh1, lo1, hi1;
  assign rl1 = {1'b0, rd_low};
  assign rh1 = {1'b0, rd_high} + 1'b1;
  assign lo1 = {1'b0, lo_r};
  assign hi1 = {1'b0, hi_r} + 1'b1;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ptr_nxt   = ptr_r;
    first_nxt = first_r;
    run_nxt   = run_r;
    lo_nxt = lo_r; hi_nxt = hi_r; key_nxt = key_r; idx_nxt = idx_r;
    ov_nxt = ov_r;
    o_hit_nxt = o_hit_r; o_ev_nxt = o_ev_r; o_lo_nxt = o_lo_r;
    o_hi_nxt = o_hi_r; o_st_nxt = o_st_r;
    cmd = CMD_HOLD; pos = ptr_r[PW-1:0]; wr = 1'b0;
    wr_low = lo_r; wr_high = hi_r;
    if (ov_r && out_ready) ov_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          lo_nxt  = in_range_low[KW-1:0];
          hi_nxt  = in_range_high[KW-1:0];
          key_nxt = in_probe_key[KW-1:0];
          idx_nxt = in_entry_index;
          ptr_nxt = '0;
          o_hit_nxt = 1'b0; o_ev_nxt = 1'b0; o_lo_nxt = '0; o_hi_nxt = '0;
          o_st_nxt = ST_OK;
          unique case (op_t'(in_operation))
            OP_CLEAR: begin
              count_nxt = '0;
              ov_nxt = 1'b1;
            end
            OP_INSERT: begin
              if (in_range_low[KW-1:0] > in_range_high[KW-1:0]) begin
                o_st_nxt = ST_REVERSED;
                ov_nxt = 1'b1;
              end else begin
                state_nxt = S_FIND;
              end
            end
            OP_QUERY: state_nxt = S_QUERY;
            OP_READ: begin
              ptr_nxt = CW'(in_entry_index);
              state_nxt = S_READ;
            end
            default: ;
          endcase
        end
      end
      S_QUERY: begin
        if (ptr_r >= count_r) begin
          ov_nxt = 1'b1; state_nxt = S_IDLE;
        end else if (key_r >= rd_low && key_r <= rd_high) begin
          o_hit_nxt = 1'b1; ov_nxt = 1'b1; state_nxt = S_IDLE;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      S_READ: begin
        if (CW'(idx_r) < count_r && 32'(idx_r) < CAPACITY) begin
          o_ev_nxt = 1'b1;
          o_lo_nxt = 20'(rd_low);
          o_hi_nxt = 20'(rd_high);
        end
        ov_nxt = 1'b1; state_nxt = S_IDLE;
      end
      S_FIND: begin
        // skip intervals that end well before the new low end
        if (ptr_r < count_r && rh1 < lo1) begin
          ptr_nxt = ptr_r + 1'b1;
        end else begin
          first_nxt = ptr_r;
          state_nxt = S_MERGE;
        end
      end
      S_MERGE: begin
        // absorb every touching interval from first onward
        if (ptr_r < count_r && rl1 <= hi1) begin
          if (rd_low < lo_r)  lo_nxt = rd_low;
          if (rd_high > hi_r) hi_nxt = rd_high;
          ptr_nxt = ptr_r + 1'b1;
        end else if (ptr_r == first_r) begin
          if (count_r >= CW'(CAPACITY)) begin
            o_st_nxt = ST_FULL; ov_nxt = 1'b1; state_nxt = S_IDLE;
          end else begin
            ptr_nxt = count_r; // S_OPEN then shifts the whole tail right at once
            run_nxt = count_r - first_r;
            state_nxt = S_OPEN;
          end
        end else begin
          run_nxt = ptr_r - first_r - 1'b1; // surplus slots to close
          ptr_nxt = first_r + 1'b1;
          count_nxt = count_r - (ptr_r - first_r) + 1'b1;
          state_nxt = S_CLOSE;
        end
      end
      S_OPEN: begin
        // the whole tail moves right one slot together, and the merged interval is written at first
        cmd = CMD_RIGHT; pos = first_r[PW-1:0];
        wr = 1'b1; wr_low = lo_r; wr_high = hi_r;
        count_nxt = count_r + 1'b1;
        ov_nxt = 1'b1; state_nxt = S_IDLE;
      end
      S_CLOSE: begin
        if (run_r != '0) begin
          cmd = CMD_LEFT; pos = ptr_r[PW-1:0];
          run_nxt = run_r - 1'b1;
        end else begin
          wr = 1'b1; pos = first_r[PW-1:0];
          ov_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
    ptr_r <= ptr_nxt; first_r <= first_nxt; run_r <= run_nxt;
    lo_r <= lo_nxt; hi_r <= hi_nxt; key_r <= key_nxt; idx_r <= idx_nxt;
    o_hit_r <= o_hit_nxt; o_ev_r <= o_ev_nxt;
    o_lo_r <= o_lo_nxt; o_hi_r <= o_hi_nxt; o_st_r <= o_st_nxt;
  end

  assign out_valid          = ov_r;
  assign out_hit            = o_hit_r;
  assign out_entry_low      = o_lo_r;
  assign out_entry_high     = o_hi_r;
  assign out_entry_valid    = o_ev_r;
  assign out_interval_count = 6'(count_r);
  assign out_status         = o_st_r;

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY)) else $error("count above capacity");
  a_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ready) else $error("ready while busy");
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
endmodule

>>> test/isuq_checker.sv
// Checker for the interval set union/query block: watches both channels,
// keeps its own copy of the interval set and compares every result beat.
// Depends on isuq_pkg.
module isuq_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [19:0] in_range_low,
  input  logic [19:0] in_range_high,
  input  logic [19:0] in_probe_key,
  input  logic [4:0]  in_entry_index,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_hit,
  input  logic [19:0] out_entry_low,
  input  logic [19:0] out_entry_high,
  input  logic        out_entry_valid,
  input  logic [5:0]  out_interval_count,
  input  logic [1:0]  out_status,
  output int          fail_count,
  output int          pending,
  output int          result_count
);
  import isuq_pkg::*;

  typedef struct packed {
    logic        hit;
    logic [19:0] elo;
    logic [19:0] ehi;
    logic        evalid;
    logic [5:0]  count;
    status_t     status;
  } answer_t;

  logic [19:0] lows [CAPACITY];
  logic [19:0] highs [CAPACITY];
  int unsigned span_count;
  answer_t     answers_due [$];

  function automatic status_t merge_interval(logic [19:0] lo, logic [19:0] hi);
    int unsigned first, last, n;
    logic [19:0] nlo, nhi;
    logic [19:0] tl [CAPACITY + 1];
    logic [19:0] th [CAPACITY + 1];
    first = 0;
    nlo = lo;
    nhi = hi;
    n = 0;
    if (lo > hi) return ST_REVERSED;
    while (first < span_count && {1'b0, highs[first]} + 21'd1 < {1'b0, lo}) first++;
    last = first;
    while (last < span_count && {1'b0, lows[last]} <= {1'b0, hi} + 21'd1) begin
      if (lows[last] < nlo) nlo = lows[last];
      if (highs[last] > nhi) nhi = highs[last];
      last++;
    end
    if (span_count - (last - first) + 1 > CAPACITY) return ST_FULL;
    for (int i = 0; i < first; i++) begin
      tl[n] = lows[i]; th[n] = highs[i]; n++;
    end
    tl[n] = nlo; th[n] = nhi; n++;
    for (int i = last; i < span_count; i++) begin
      tl[n] = lows[i]; th[n] = highs[i]; n++;
    end
    for (int i = 0; i < n; i++) begin
      lows[i] = tl[i]; highs[i] = th[i];
    end
    span_count = n;
    return ST_OK;
  endfunction

  function automatic answer_t apply_op(op_t op, logic [19:0] lo, logic [19:0] hi,
                                       logic [19:0] key, logic [4:0] idx);
    answer_t a;
    a = '0;
    a.status = ST_OK;
    case (op)
      OP_CLEAR: span_count = 0;
      OP_INSERT: a.status = merge_interval(lo, hi);
      OP_QUERY: begin
        for (int i = 0; i < span_count; i++)
          if (key >= lows[i] && key <= highs[i]) a.hit = 1'b1;
      end
      default: begin
        if (idx < span_count) begin
          a.evalid = 1'b1;
          a.elo = lows[idx];
          a.ehi = highs[idx];
        end
      end
    endcase
    a.count = span_count[5:0];
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t want, got, due;
    if (!rst_n) begin
      span_count = 0;
      answers_due.delete();
      fail_count = 0;
      result_count = 0;
    end else begin
      if (in_valid && in_ready) begin
        due = apply_op(op_t'(in_operation), in_range_low, in_range_high,
                       in_probe_key, in_entry_index);
        answers_due = {answers_due, due};
      end
      if (out_valid && out_ready) begin
        got = '{out_hit, out_entry_low, out_entry_high, out_entry_valid,
                out_interval_count, status_t'(out_status)};
        result_count++;
        if (answers_due.size() == 0) begin
          $display("%0t: result beat with nothing expected: %p", $time, got);
          fail_count++;
        end else begin
          want = answers_due.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, got);
            fail_count++;
          end
        end
      end
    end
    pending = answers_due.size();
  end
endmodule

>>> test/interval_set_union_query_top_test.sv
// Testbench top for interval_set_union_query_top: drives operations with
// bursty valid and a stalling receiver; isuq_checker does the checking.
// Depends on isuq_pkg, isuq_checker and the block.
module interval_set_union_query_top_test;
  import isuq_pkg::*;

  logic        clk, rst_n;
  logic        in_valid, in_ready;
  logic [1:0]  in_operation;
  logic [19:0] in_range_low, in_range_high, in_probe_key;
  logic [4:0]  in_entry_index;
  logic        out_valid, out_ready;
  logic        out_hit, out_entry_valid;
  logic [19:0] out_entry_low, out_entry_high;
  logic [5:0]  out_interval_count;
  logic [1:0]  out_status;
  int          fail_count, pending, result_count;
  bit          stim_done;

  interval_set_union_query_top u_top (.*);
  isuq_checker u_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("interval_set_union_query_top_test: FAIL");
    $finish;
  end

  // receiver: random stalls, one long hold-off to back up the input
  initial begin
    out_ready = 1'b0;
    @(posedge clk iff rst_n);
    repeat (400) begin
      @(posedge clk);
      out_ready <= ($urandom_range(0, 3) != 0);
    end
    out_ready <= 1'b0;
    repeat (300) @(posedge clk);
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 9) < 2) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 2) != 0);
    end
  end

  task automatic send(op_t op, logic [19:0] lo, logic [19:0] hi,
                      logic [19:0] key, logic [4:0] idx);
    in_valid <= 1'b1;
    in_operation <= op;
    in_range_low <= lo;
    in_range_high <= hi;
    in_probe_key <= key;
    in_entry_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic pause_random();
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [19:0] pick_key(int unsigned style);
    case (style)
      0: return 20'($urandom_range(0, 63));
      1: return 20'hFFFFF - 20'($urandom_range(0, 63));
      default: return 20'($urandom());
    endcase
  endfunction

  initial begin
    int unsigned style, burst;
    logic [19:0] a, b;
    op_t op;
    in_valid = 1'b0;
    in_operation = OP_CLEAR;
    in_range_low = '0;
    in_range_high = '0;
    in_probe_key = '0;
    in_entry_index = '0;
    rst_n = 1'b0;
    stim_done = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: extremes, touching and reversed intervals, full set
    send(OP_READ, 0, 0, 0, 0);
    send(OP_QUERY, 0, 0, 0, 0);
    send(OP_INSERT, 0, 0, 0, 0);
    send(OP_INSERT, 20'hFFFFF, 20'hFFFFF, 0, 0);
    send(OP_INSERT, 20'd5, 20'd4, 0, 0);
    send(OP_INSERT, 20'd2, 20'd3, 0, 0);
    send(OP_INSERT, 20'd1, 20'd1, 0, 0);
    send(OP_QUERY, 0, 0, 20'hFFFFF, 0);
    send(OP_QUERY, 0, 0, 20'd4, 0);
    send(OP_READ, 0, 0, 0, 0);
    send(OP_READ, 0, 0, 0, 1);
    send(OP_READ, 0, 0, 0, 31);
    send(OP_INSERT, 0, 20'hFFFFF, 0, 0);
    send(OP_READ, 0, 0, 0, 0);
    send(OP_CLEAR, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 31);
    for (int i = 0; i < 33; i++) send(OP_INSERT, 20'(i * 4), 20'(i * 4 + 1), 0, 0);
    send(OP_READ, 0, 0, 0, 31);
    send(OP_INSERT, 20'd2, 20'd2, 0, 0);
    send(OP_QUERY, 0, 0, 20'd127, 0);
    send(OP_CLEAR, 0, 0, 0, 0);
    // random: bursts of inserts, mostly well-formed, mixed with queries, reads and rare clears
    for (int n = 0; n < 1900; n += burst) begin
      burst = $urandom_range(1, 20);
      style = $urandom_range(0, 2);
      for (int k = 0; k < burst; k++) begin
        case ($urandom_range(0, 39))
          0: op = OP_CLEAR;
          1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15, 16: op = OP_INSERT;
          17, 18, 19, 20, 21, 22, 23, 24, 25, 26, 27, 28: op = OP_QUERY;
          default: op = OP_READ;
        endcase
        a = pick_key(style);
        b = ($urandom_range(0, 15) == 0) ? pick_key(style)
                                          : 20'(a + 20'($urandom_range(0, 6)));
        if (b < a && $urandom_range(0, 1)) b = 20'hFFFFF;
        send(op, a, b, pick_key(style), 5'($urandom()));
      end
      pause_random();
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Ran directed edge cases and about 1950 random operations of every kind,");
    $display("incl. full-set and reversed inserts; %0d result beats checked.", result_count);
    if (fail_count == 0) $display("interval_set_union_query_top_test: PASS");
    else $display("interval_set_union_query_top_test: FAIL");
    $finish;
  end
endmodule

>>> sim.f
rtl/isuq_pkg.sv
rtl/isuq_cell.sv
rtl/isuq_row.sv
rtl/interval_set_union_query_top.sv
test/isuq_checker.sv
test/interval_set_union_query_top_test.sv
